// ===== hw/rtl/proximity_alert_sequencer_assert.svh =====
// Assertion macros shared by the proximity alert sequencer RTL.
// Each macro uses the enclosing module's clk and rst.
`ifndef PROXIMITY_ALERT_SEQUENCER_ASSERT_SVH
`define PROXIMITY_ALERT_SEQUENCER_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define PAS_ASSERT_HOLDS(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("proximity alert sequencer check failed");

// The consequent holds in the cycle after the antecedent.
`define PAS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("proximity alert sequencer check failed");

`endif

// ===== hw/rtl/pas_pkg.sv =====
package pas_pkg;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;

  typedef enum logic [1:0] {
    LVL_OK   = 2'd0,
    LVL_WARN = 2'd1,
    LVL_CRIT = 2'd2
  } level_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_NEAR_THRESHOLD = 3'd0,
    REG_WARNING_TIME   = 3'd1,
    REG_CRITICAL_TIME  = 3'd2,
    REG_PULSE_LENGTH   = 3'd3,
    REG_PULSE_PAUSE    = 3'd4,
    REG_PULSE_COUNT    = 3'd5,
    REG_BLINK_PERIOD   = 3'd6
  } reg_index_t;

  localparam logic [14:0] NEAR_THRESHOLD_RESET = 15'd800;
  localparam logic [15:0] WARNING_TIME_RESET   = 16'd3000;
  localparam logic [15:0] CRITICAL_TIME_RESET  = 16'd3000;
  localparam logic [15:0] PULSE_LENGTH_RESET   = 16'd200;
  localparam logic [15:0] PULSE_PAUSE_RESET    = 16'd200;
  localparam logic [3:0]  PULSE_COUNT_RESET    = 4'd3;
  localparam logic [15:0] BLINK_PERIOD_RESET   = 16'd500;

endpackage

// ===== hw/rtl/proximity_alert_sequencer.sv =====
// Proximity alert sequencer.
// Input channel: in_valid/in_stall carry now_ms (millisecond timestamp) and
// distance (signed Q12.4 cm). An item is taken when in_valid is high and
// in_stall is low. Each input item produces exactly one result item.
// Output channel: out_valid/out_stall carry the LED drives, the buzzer drive
// and alert_level. The receiver holds out_stall high to keep a result.
// Configuration: cfg_valid/cfg_ready write cfg_data into register cfg_index;
// cfg_ready is always high and writes are meant for an idle block.
// The accepting edge loads the input register; a later edge on which the
// output is not stalled updates the state and loads the result register.
// Throughput is one item per cycle while the receiver does not stall.
// When the receiver stalls, the held result stays, one more item may sit in
// the input register, and in_stall rises until the result is taken.
// Synchronous reset returns the level to ok, clears all timers and flags,
// empties both registers and loads the default configuration values.
module proximity_alert_sequencer #(
  parameter int TIME_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [31:0]                         now_ms,
  input  logic signed [15:0]                  distance,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                red_on,
  output logic                                green_on,
  output logic                                blue_on,
  output logic                                buzzer_on,
  output logic [1:0]                          alert_level,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pas_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [pas_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import pas_pkg::*;

  `include "proximity_alert_sequencer_assert.svh"

  localparam int CW = (TIME_BITS > 17) ? TIME_BITS : 17;

  typedef logic [TIME_BITS-1:0] time_t;

  typedef struct packed {
    level_t     level;
    time_t      level_start;
    time_t      pulse_start;
    time_t      blink_start;
    logic [3:0] pulses_done;
    logic       buzzing;
    logic       single_beep_done;
    logic       pattern_active;
    logic       lamp_phase;
  } seq_state_t;

  function automatic seq_state_t enter_level(level_t nxt, time_t now);
    seq_state_t r;
    r.level            = nxt;
    r.level_start      = now;
    r.pulse_start      = now;
    r.blink_start      = now;
    r.pulses_done      = 4'd0;
    r.buzzing          = (nxt == LVL_WARN) || (nxt == LVL_CRIT);
    r.single_beep_done = 1'b0;
    r.pattern_active   = (nxt == LVL_CRIT);
    r.lamp_phase       = 1'b0;
    return r;
  endfunction

  logic [14:0] near_threshold;
  logic [15:0] warning_time;
  logic [15:0] critical_time;
  logic [15:0] pulse_length;
  logic [15:0] pulse_pause;
  logic [3:0]  pulse_count;
  logic [15:0] blink_period;

  logic               in_q_valid;
  time_t              now_q;
  logic signed [15:0] dist_q;

  seq_state_t st;
  seq_state_t st_next;
  seq_state_t s;
  time_t      elapsed;
  logic       near;
  logic       advance;
  logic       red_next;
  logic       green_next;

  assign cfg_ready = 1'b1;
  assign blue_on   = 1'b0;
  assign advance   = !out_valid || !out_stall;
  assign in_stall  = in_q_valid && !advance;
  assign near      = !dist_q[15] && (dist_q[14:0] < near_threshold);

  always_ff @(posedge clk) begin
    if (rst) begin
      near_threshold <= NEAR_THRESHOLD_RESET;
      warning_time   <= WARNING_TIME_RESET;
      critical_time  <= CRITICAL_TIME_RESET;
      pulse_length   <= PULSE_LENGTH_RESET;
      pulse_pause    <= PULSE_PAUSE_RESET;
      pulse_count    <= PULSE_COUNT_RESET;
      blink_period   <= BLINK_PERIOD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_NEAR_THRESHOLD: near_threshold <= cfg_data[14:0];
        REG_WARNING_TIME:   warning_time   <= cfg_data;
        REG_CRITICAL_TIME:  critical_time  <= cfg_data;
        REG_PULSE_LENGTH:   pulse_length   <= cfg_data;
        REG_PULSE_PAUSE:    pulse_pause    <= cfg_data;
        REG_PULSE_COUNT:    pulse_count    <= cfg_data[3:0];
        REG_BLINK_PERIOD:   blink_period   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    s          = st;
    elapsed    = '0;
    red_next   = 1'b0;
    green_next = 1'b0;

    if (near) begin
      if (s.level == LVL_OK) begin
        s = enter_level(LVL_WARN, now_q);
      end
      elapsed = now_q - s.level_start;
      if (s.level == LVL_WARN && CW'(elapsed) >= CW'(warning_time)) begin
        s = enter_level(LVL_CRIT, now_q);
      end else if (s.level == LVL_CRIT &&
                   CW'(elapsed) >= CW'(warning_time) + CW'(critical_time)) begin
        s = enter_level(LVL_WARN, now_q);
      end
    end else if (s.level != LVL_OK) begin
      s = enter_level(LVL_OK, now_q);
    end

    unique case (s.level)
      LVL_WARN: begin
        if (!s.single_beep_done && s.buzzing &&
            CW'(now_q - s.pulse_start) >= CW'(pulse_length)) begin
          s.buzzing          = 1'b0;
          s.single_beep_done = 1'b1;
        end
      end
      LVL_CRIT: begin
        if (s.pattern_active) begin
          priority if (s.pulses_done >= pulse_count) begin
            s.buzzing        = 1'b0;
            s.pattern_active = 1'b0;
          end else if (s.buzzing &&
                       CW'(now_q - s.pulse_start) >= CW'(pulse_length)) begin
            s.buzzing     = 1'b0;
            s.pulse_start = now_q;
          end else if (!s.buzzing &&
                       CW'(now_q - s.pulse_start) >= CW'(pulse_pause)) begin
            s.pulses_done = 4'(s.pulses_done + 4'd1);
            if (s.pulses_done < pulse_count) begin
              s.buzzing     = 1'b1;
              s.pulse_start = now_q;
            end else begin
              s.buzzing        = 1'b0;
              s.pattern_active = 1'b0;
            end
          end else begin
            // The current pulse or pause is still running.
          end
        end
      end
      default: begin
        s.buzzing = 1'b0;
      end
    endcase

    if (s.level != LVL_OK) begin
      if (CW'(now_q - s.blink_start) >= CW'(blink_period)) begin
        s.blink_start = now_q;
        s.lamp_phase  = !s.lamp_phase;
      end
      red_next   = s.lamp_phase;
      green_next = s.lamp_phase && (s.level == LVL_WARN);
    end

    st_next = s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
      out_valid  <= 1'b0;
      st         <= '{level: LVL_OK, level_start: '0, pulse_start: '0,
                      blink_start: '0, pulses_done: 4'd0, buzzing: 1'b0,
                      single_beep_done: 1'b0, pattern_active: 1'b0,
                      lamp_phase: 1'b0};
    end else begin
      if (!in_stall) begin
        in_q_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= in_q_valid;
        if (in_q_valid) begin
          st <= st_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      now_q  <= TIME_BITS'(now_ms);
      dist_q <= distance;
    end
    if (advance && in_q_valid) begin
      red_on      <= red_next;
      green_on    <= green_next;
      buzzer_on   <= st_next.buzzing;
      alert_level <= st_next.level;
    end
  end

  `PAS_ASSERT_HOLDS(a_ok_is_quiet, st.level == LVL_OK, !st.buzzing && !st.pattern_active && !st.lamp_phase)
  `PAS_ASSERT_HOLDS(a_pattern_only_critical, st.pattern_active, st.level == LVL_CRIT)
  `PAS_ASSERT_HOLDS(a_ok_result_dark, out_valid && alert_level == LVL_OK, !red_on && !green_on && !buzzer_on)
  `PAS_ASSERT_NEXT(a_item_reaches_output, in_q_valid && advance, out_valid)

endmodule
